// ===== rtl/core/csrmv_pkg.sv =====
// ----------------------------------------------------------------------------
// csrmv_pkg
// Shared types and constants of the CSR sparse matrix-vector multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package csrmv_pkg;

    // Default sizing of the vector store and value format
    localparam int DEF_VECTOR_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH  = 32;

    // Fixed field widths of the stream items
    localparam int FRAC_BITS  = 16;
    localparam int ACC_WIDTH  = 48;
    localparam int ROW_WIDTH  = 10;
    localparam int POS_WIDTH  = 10;
    localparam int OPND_WIDTH = 32;
    localparam int SUM_WIDTH  = 32;
    localparam int CFG_WIDTH  = 11;
    localparam int TYPE_WIDTH = 2;

    // Packed stream data widths, padded to whole bytes
    localparam int S_DATA_WIDTH = ((POS_WIDTH + OPND_WIDTH + 7) / 8) * 8;
    localparam int M_DATA_WIDTH = ((SUM_WIDTH + ROW_WIDTH + 7) / 8) * 8;

    localparam logic [CFG_WIDTH-1:0] ROW_COUNT_RESET = CFG_WIDTH'(1024);

    // Request codes
    typedef enum logic [TYPE_WIDTH-1:0] {
        REQ_LOAD    = 2'd0,
        REQ_NONZERO = 2'd1,
        REQ_EMPTY   = 2'd2
    } req_type_t;

    // Control of one item in flight
    typedef struct packed {
        logic nonzero;
        logic empty;
        logic last;
    } item_ctrl_t;

    // One row result
    typedef struct packed {
        logic [SUM_WIDTH-1:0] row_sum;
        logic [ROW_WIDTH-1:0] row_number;
        logic                 saturated;
    } row_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/csr_sparse_matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// csr_sparse_matrix_vector_multiply
// Sparse matrix times dense vector, matrix streamed in compressed-row order,
// signed fixed point with 16 fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one request per beat. tuser selects load vector entry,
//   matrix nonzero or empty row; tlast marks the final nonzero of a row.
//   Master stream m_*: one row result per beat, for every nonzero with tlast
//   and for every empty-row request. Loads give no beat.
//   cfg_*: write of row_count, always ready; write it only while idle.
// Pipeline: a result beat shows on m_tvalid once its request beat is taken
//   (vector read at the taking edge), multiplied into the product register
//   and accumulated into the output register. Throughput is one request per
//   cycle unless the output stalls, set by the accumulate closing the loop.
// Reset: accumulator and row index clear, row_count returns to 1024. The
//   vector store is not cleared; read only entries that were loaded.
// Stall: the output register holds its beat while m_tready is low; the
//   two inner stages keep filling, and s_tready drops only once both hold
//   an item and the one in front needs the blocked output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csr_sparse_matrix_vector_multiply #(
    parameter int VECTOR_DEPTH = csrmv_pkg::DEF_VECTOR_DEPTH,
    parameter int VALUE_WIDTH  = csrmv_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Requests
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: position [9:0], operand_value [41:10], zero pad [47:42]
    input  logic [csrmv_pkg::S_DATA_WIDTH-1:0]   s_tdata,
    // tuser: req_type [1:0]
    input  logic [csrmv_pkg::TYPE_WIDTH-1:0]     s_tuser,
    input  logic                                 s_tlast,
    // Row results
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: row_sum [31:0], row_number [41:32], zero pad [47:42]
    output logic [csrmv_pkg::M_DATA_WIDTH-1:0]   m_tdata,
    // tuser: saturated [0]
    output logic [0:0]                           m_tuser,
    // Configuration: row_count
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csrmv_pkg::CFG_WIDTH-1:0]      cfg_data
);

    import csrmv_pkg::*;

    localparam int ADDR_W = $clog2(VECTOR_DEPTH);
    localparam int PROD_W = 2 * VALUE_WIDTH;

    // Request fields
    logic [POS_WIDTH-1:0]   in_pos;
    logic [OPND_WIDTH-1:0]  in_opnd;
    logic [31:0]            pos_ext;
    logic [ADDR_W-1:0]      in_addr;
    logic                   in_pos_ok;
    logic                   is_load;
    logic                   is_nonzero;
    logic                   is_empty;
    logic                   accept;

    // Stage 1: request plus vector read
    logic                   s1_valid_reg;
    item_ctrl_t             s1_ctrl_reg;
    logic [VALUE_WIDTH-1:0] s1_opnd_reg;
    logic                   s1_pos_ok_reg;
    logic [VALUE_WIDTH-1:0] vec_data;
    logic signed [VALUE_WIDTH-1:0] mul_a;
    logic signed [VALUE_WIDTH-1:0] mul_b;
    logic signed [PROD_W-1:0]      mul_p;

    // Stage 2: product
    logic                   s2_valid_reg;
    item_ctrl_t             s2_ctrl_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic                   s2_emits;
    row_result_t            s2_result;

    // Output register
    logic                   out_valid_reg;
    row_result_t            out_result_reg;

    logic [CFG_WIDTH-1:0]   row_count_reg;

    logic                   out_free;
    logic                   s2_go;
    logic                   s2_ready;
    logic                   s1_go;

    // Decode the request beat
    always_comb
    begin
        in_pos     = s_tdata[POS_WIDTH-1:0];
        in_opnd    = s_tdata[POS_WIDTH+OPND_WIDTH-1:POS_WIDTH];
        pos_ext    = 32'(in_pos);
        in_addr    = pos_ext[ADDR_W-1:0];
        in_pos_ok  = (pos_ext < 32'(VECTOR_DEPTH));
        is_load    = (s_tuser == REQ_LOAD);
        is_nonzero = (s_tuser == REQ_NONZERO);
        is_empty   = (s_tuser == REQ_EMPTY);
    end

    // Pipeline flow control
    always_comb
    begin
        out_free = ~out_valid_reg | m_tready;
        s2_emits = s2_ctrl_reg.empty | (s2_ctrl_reg.nonzero & s2_ctrl_reg.last);
        s2_go    = s2_valid_reg & (~s2_emits | out_free);
        s2_ready = ~s2_valid_reg | s2_go;
        s1_go    = s1_valid_reg & s2_ready;
        s_tready = ~s1_valid_reg | s1_go;
        accept   = s_tvalid & s_tready;
    end

    // Vector store
    csrmv_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec_ram (
        .clk     (clk),
        .wr_en   (accept & is_load & in_pos_ok),
        .wr_addr (in_addr),
        .wr_data (in_opnd[VALUE_WIDTH-1:0]),
        .rd_en   (accept & is_nonzero),
        .rd_addr (in_addr),
        .rd_data (vec_data)
    );

    // Multiply operand by vector entry; a column beyond the store reads zero
    always_comb
    begin
        mul_a = s1_opnd_reg;
        mul_b = s1_pos_ok_reg ? vec_data : '0;
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Accumulate and saturate
    csrmv_acc #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (s2_go),
        .ctrl      (s2_ctrl_reg),
        .prod      (s2_prod_reg),
        .row_count (row_count_reg),
        .result    (s2_result)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            row_count_reg <= ROW_COUNT_RESET;
        end
        else
        begin
            // Loads finish at the RAM, unused codes are dropped; neither occupies a stage
            if (accept)
            begin
                s1_valid_reg <= is_nonzero | is_empty;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_go)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_go && s2_emits)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid)
            begin
                row_count_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctrl_reg.nonzero <= is_nonzero;
            s1_ctrl_reg.empty   <= is_empty;
            s1_ctrl_reg.last    <= s_tlast;
            s1_opnd_reg         <= in_opnd[VALUE_WIDTH-1:0];
            s1_pos_ok_reg       <= in_pos_ok;
        end
        if (s1_go)
        begin
            s2_ctrl_reg <= s1_ctrl_reg;
            s2_prod_reg <= mul_p;
        end
        if (s2_go && s2_emits)
        begin
            out_result_reg <= s2_result;
        end
    end

    assign cfg_ready  = 1'b1;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{(M_DATA_WIDTH-SUM_WIDTH-ROW_WIDTH){1'b0}},
                         out_result_reg.row_number, out_result_reg.row_sum};
    assign m_tuser[0] = out_result_reg.saturated;

endmodule

`default_nettype wire

// ===== rtl/core/csrmv_ram.sv =====
// ----------------------------------------------------------------------------
// csrmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csrmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold data when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/csrmv_acc.sv =====
// ----------------------------------------------------------------------------
// csrmv_acc
// Row accumulator: scales the product, adds it up, saturates the row sum
// and tracks the current row index.
// ----------------------------------------------------------------------------
`default_nettype none

module csrmv_acc #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  go,
    input  csrmv_pkg::item_ctrl_t                 ctrl,
    input  logic signed [2*VALUE_WIDTH-1:0]       prod,
    input  logic [csrmv_pkg::CFG_WIDTH-1:0]       row_count,
    output csrmv_pkg::row_result_t                result
);

    import csrmv_pkg::*;

    logic signed [ACC_WIDTH-1:0]   acc_reg;
    logic signed [ACC_WIDTH-1:0]   acc_next;
    logic [ROW_WIDTH-1:0]          row_reg;
    logic [ROW_WIDTH-1:0]          row_next;
    logic [ROW_WIDTH-1:0]          row_inc;

    logic signed [63:0]            prod_wide;
    logic signed [63:0]            q_wide;
    logic signed [ACC_WIDTH-1:0]   q;
    logic signed [ACC_WIDTH-1:0]   sum;
    logic [ACC_WIDTH-VALUE_WIDTH:0] upper;
    logic                          fits;
    logic signed [VALUE_WIDTH-1:0] clip;

    // Floor-shift the product back to the fixed-point grid, then add
    always_comb
    begin
        prod_wide = 64'(prod);
        q_wide    = prod_wide >>> FRAC_BITS;
        q         = q_wide[ACC_WIDTH-1:0];
        sum       = acc_reg + q;
    end

    // Clamp the sum to the value range
    always_comb
    begin
        upper = sum[ACC_WIDTH-1:VALUE_WIDTH-1];
        fits  = (&upper) | ~(|upper);
        if (fits)
        begin
            clip = sum[VALUE_WIDTH-1:0];
        end
        else if (sum[ACC_WIDTH-1])
        begin
            clip = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end
        else
        begin
            clip = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
    end

    // Build the row result; an empty row reports zero
    always_comb
    begin
        result.row_number = row_reg;
        if (ctrl.empty)
        begin
            result.row_sum   = '0;
            result.saturated = 1'b0;
        end
        else
        begin
            result.row_sum   = SUM_WIDTH'(clip);
            result.saturated = ~fits;
        end
    end

    // Next accumulator and row index
    always_comb
    begin
        acc_next = acc_reg;
        row_next = row_reg;
        row_inc  = row_reg + 1'b1;
        if (go && ctrl.nonzero)
        begin
            acc_next = ctrl.last ? '0 : sum;
        end
        if (go && (ctrl.empty || (ctrl.nonzero && ctrl.last)))
        begin
            row_next = ({1'b0, row_inc} >= row_count) ? '0 : row_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/csrmv_checker.sv =====
// ----------------------------------------------------------------------------
// csrmv_checker
// Port-level checks of the sparse matrix-vector multiplier, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module csrmv_checker #(
    parameter int VALUE_WIDTH = csrmv_pkg::DEF_VALUE_WIDTH
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tready,
    input  wire                                m_tvalid,
    input  wire                                m_tready,
    input  wire [csrmv_pkg::M_DATA_WIDTH-1:0]  m_tdata,
    input  wire [0:0]                          m_tuser,
    input  wire                                cfg_valid,
    input  wire                                cfg_ready
);

    import csrmv_pkg::*;

    localparam logic [63:0] MAX_WIDE = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
    localparam logic [SUM_WIDTH-1:0] SAT_MAX = MAX_WIDE[SUM_WIDTH-1:0];
    localparam logic [SUM_WIDTH-1:0] SAT_MIN = ~SAT_MAX;

    // Stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A clipped sum sits at one end of the value range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            (m_tdata[SUM_WIDTH-1:0] == SAT_MAX) || (m_tdata[SUM_WIDTH-1:0] == SAT_MIN))
        else $error("saturated flag with an unclipped sum");

    // An empty output register never blocks requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request stalled with output register empty");

    // Configuration is always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind csr_sparse_matrix_vector_multiply csrmv_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_checker (.*);

`default_nettype wire
